[design/bht_pkg.sv]
// Package: shared types, constants and codes for the bucketed hash table.
package bht_pkg;
  localparam int NUM_BUCKETS_DEF      = 64;
  localparam int SLOTS_PER_BUCKET_DEF = 5;
  localparam int OVERFLOW_DEPTH_DEF   = 8;
  localparam int KEY_WIDTH_DEF        = 32;

  localparam int TS_W  = 7;
  localparam int OS_W  = 4;
  localparam int CFG_W = 7;
  localparam int BI_W  = 6;
  localparam int FC_W  = 3;

  localparam logic [TS_W-1:0] TS_RESET = 7'd64;
  localparam logic [OS_W-1:0] OS_RESET = 4'd8;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    LOC_BUCKET   = 2'd0,
    LOC_OVERFLOW = 2'd1,
    LOC_NOWHERE  = 2'd2
  } loc_t;

  typedef enum logic {
    REG_TABLE_SIZE     = 1'b0,
    REG_OVERFLOW_SLOTS = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_DIV,
    FS_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    BS_CLEAR,
    BS_IDLE,
    BS_READ,
    BS_SLOTS,
    BS_OVF,
    BS_WRITE,
    BS_OUT
  } back_state_t;
endpackage

[design/bht_front.sv]
// Front end: accepts requests and computes the bucket index by restoring division.
module bht_front #(
  parameter int KEY_WIDTH = bht_pkg::KEY_WIDTH_DEF,
  parameter int NUM_BUCKETS = bht_pkg::NUM_BUCKETS_DEF,
  parameter int BW = $clog2(NUM_BUCKETS)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_cmd,
  input  logic [KEY_WIDTH-1:0]   in_key,
  input  logic [bht_pkg::TS_W-1:0] table_size,
  output logic                   q_push,
  input  logic                   q_full,
  output logic [1:0]             q_cmd,
  output logic [KEY_WIDTH-1:0]   q_key,
  output logic [BW-1:0]          q_bucket
);
  localparam int CW = $clog2(KEY_WIDTH + 1);
  localparam int RW = BW + 2;

  bht_pkg::front_state_t state_r, state_nxt;
  logic [1:0]           cmd_r;
  logic [KEY_WIDTH-1:0] key_r, quo_r, quo_nxt;
  logic [RW-1:0]        rem_r, rem_nxt, div_r, sh;
  logic [CW-1:0]        cnt_r;
  logic [RW-1:0]        div_eff;

  // effective table size, clamped to 1..NUM_BUCKETS
  always_comb begin
    if (table_size == '0) div_eff = RW'(1);
    else if (32'(table_size) > NUM_BUCKETS) div_eff = RW'(NUM_BUCKETS);
    else div_eff = RW'(table_size);
  end

  // one quotient bit per cycle
  always_comb begin
    sh = {rem_r[RW-2:0], quo_r[KEY_WIDTH-1]};
    quo_nxt = {quo_r[KEY_WIDTH-2:0], 1'b0};
    rem_nxt = sh;
    if (sh >= div_r) begin
      rem_nxt = sh - div_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_stall = 1'b1;
    q_push = 1'b0;
    unique case (state_r)
      bht_pkg::FS_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) state_nxt = bht_pkg::FS_DIV;
      end
      bht_pkg::FS_DIV: begin
        if (cnt_r == CW'(KEY_WIDTH - 1)) state_nxt = bht_pkg::FS_PUSH;
      end
      bht_pkg::FS_PUSH: begin
        if (!q_full) begin
          q_push = 1'b1;
          state_nxt = bht_pkg::FS_IDLE;
        end
      end
      default: state_nxt = bht_pkg::FS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bht_pkg::FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == bht_pkg::FS_IDLE && in_valid) begin
      cmd_r <= in_cmd;
      key_r <= in_key;
      quo_r <= in_key;
      rem_r <= '0;
      div_r <= div_eff;
      cnt_r <= '0;
    end else if (state_r == bht_pkg::FS_DIV) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
      cnt_r <= cnt_r + CW'(1);
    end
  end

  assign q_cmd = cmd_r;
  assign q_key = key_r;
  assign q_bucket = rem_r[BW-1:0];
endmodule

[design/bht_queue.sv]
// Small FIFO between the front end and the table engine.
module bht_queue #(
  parameter int W = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic         empty,
  output logic [W-1:0] dout
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign dout = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
      if (pop) rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end
endmodule

[design/bht_engine.sv]
// Table engine: bucket read-modify-write, overflow scan and result register.
module bht_engine #(
  parameter int KEY_WIDTH = bht_pkg::KEY_WIDTH_DEF,
  parameter int NUM_BUCKETS = bht_pkg::NUM_BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = bht_pkg::SLOTS_PER_BUCKET_DEF,
  parameter int OVERFLOW_DEPTH = bht_pkg::OVERFLOW_DEPTH_DEF,
  parameter int BW = $clog2(NUM_BUCKETS)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  output logic                     q_pop,
  input  logic [1:0]               q_cmd,
  input  logic [KEY_WIDTH-1:0]     q_key,
  input  logic [BW-1:0]            q_bucket,
  input  logic [bht_pkg::OS_W-1:0] overflow_slots,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_success,
  output logic [1:0]               out_location,
  output logic [bht_pkg::BI_W-1:0] out_bucket_index,
  output logic [bht_pkg::FC_W-1:0] out_fill_count
);
  localparam int S = SLOTS_PER_BUCKET;
  localparam int SW = (S > 1) ? $clog2(S) : 1;
  localparam int FW = $clog2(S + 1);
  localparam int OW = (OVERFLOW_DEPTH > 1) ? $clog2(OVERFLOW_DEPTH) : 1;
  localparam int OCW = $clog2(OVERFLOW_DEPTH + 1);

  // bucket memory: one row of keys and one row of valid bits per bucket;
  // the valid rows are cleared by a pass over all buckets after reset
  logic [KEY_WIDTH-1:0] row_mem [NUM_BUCKETS][S];
  logic [S-1:0]         bvalid_r [NUM_BUCKETS];
  logic [KEY_WIDTH-1:0] okey_r [OVERFLOW_DEPTH];
  logic [OVERFLOW_DEPTH-1:0] ovalid_r;

  bht_pkg::back_state_t state_r, state_nxt;
  logic [BW-1:0]        clr_r;
  logic [1:0]           cmd_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [BW-1:0]        bkt_r;
  logic [KEY_WIDTH-1:0] row_r [S];
  logic [S-1:0]         rv_r;
  logic [S-1:0]         rv_upd;
  logic [SW-1:0]        sidx_r;
  logic [OW-1:0]        oi_r;
  logic [OCW-1:0]       ocnt_r;
  logic [OCW-1:0]       oeff;
  logic                 ok_r;
  logic [1:0]           loc_r;
  logic [FW-1:0]        fill;

  assign oeff = (32'(overflow_slots) > OVERFLOW_DEPTH) ? OCW'(OVERFLOW_DEPTH)
                                                      : OCW'(overflow_slots);

  // fill count of the current bucket from its registered valid row
  always_comb begin
    fill = '0;
    for (int i = 0; i < S; i++) fill = fill + FW'(rv_r[i]);
  end

  // valid row after the slot update of an insert or delete
  always_comb begin
    rv_upd = rv_r;
    if (cmd_r == bht_pkg::CMD_INSERT) rv_upd[sidx_r] = 1'b1;
    else if (cmd_r == bht_pkg::CMD_DELETE) rv_upd[sidx_r] = 1'b0;
  end

  // first free slot (insert) or first matching slot (search/delete)
  logic          fhit;
  logic [SW-1:0] fidx;
  always_comb begin
    fhit = 1'b0;
    fidx = '0;
    for (int i = S - 1; i >= 0; i--) begin
      if (cmd_r == bht_pkg::CMD_INSERT) begin
        if (!rv_r[i]) begin
          fhit = 1'b1;
          fidx = SW'(i);
        end
      end else if (rv_r[i] && row_r[i] == key_r) begin
        fhit = 1'b1;
        fidx = SW'(i);
      end
    end
  end

  logic o_end, o_match;
  assign o_end = (ocnt_r >= oeff);
  assign o_match = (cmd_r == bht_pkg::CMD_INSERT) ? !ovalid_r[oi_r]
                 : (ovalid_r[oi_r] && okey_r[oi_r] == key_r);

  always_comb begin
    state_nxt = state_r;
    q_pop = 1'b0;
    unique case (state_r)
      bht_pkg::BS_CLEAR: begin
        if (clr_r == BW'(NUM_BUCKETS - 1)) state_nxt = bht_pkg::BS_IDLE;
      end
      bht_pkg::BS_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          state_nxt = bht_pkg::BS_READ;
        end
      end
      bht_pkg::BS_READ: state_nxt = bht_pkg::BS_SLOTS;
      bht_pkg::BS_SLOTS: begin
        if (cmd_r == bht_pkg::CMD_NONE) state_nxt = bht_pkg::BS_OUT;
        else if (fhit) state_nxt = bht_pkg::BS_WRITE;
        else state_nxt = bht_pkg::BS_OVF;
      end
      bht_pkg::BS_OVF: begin
        if (o_end || o_match) state_nxt = bht_pkg::BS_OUT;
      end
      bht_pkg::BS_WRITE: state_nxt = bht_pkg::BS_OUT;
      bht_pkg::BS_OUT: begin
        if (!out_stall) state_nxt = bht_pkg::BS_IDLE;
      end
      default: state_nxt = bht_pkg::BS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bht_pkg::BS_CLEAR;
      clr_r <= '0;
      ovalid_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == bht_pkg::BS_CLEAR) clr_r <= clr_r + BW'(1);
      if (state_r == bht_pkg::BS_OVF && !o_end && o_match) begin
        if (cmd_r == bht_pkg::CMD_INSERT) ovalid_r[oi_r] <= 1'b1;
        else if (cmd_r == bht_pkg::CMD_DELETE) ovalid_r[oi_r] <= 1'b0;
      end
    end
  end

  // valid rows: clearing pass, then one row write per insert or delete
  always_ff @(posedge clk) begin
    if (state_r == bht_pkg::BS_CLEAR) begin
      bvalid_r[clr_r] <= '0;
    end else if (state_r == bht_pkg::BS_WRITE && cmd_r != bht_pkg::CMD_SEARCH) begin
      bvalid_r[bkt_r] <= rv_upd;
    end
  end

  // row read and slot write of the bucket memory
  always_ff @(posedge clk) begin
    if (state_r == bht_pkg::BS_IDLE) begin
      for (int i = 0; i < S; i++) row_r[i] <= row_mem[q_bucket][i];
    end
    if (state_r == bht_pkg::BS_WRITE && cmd_r == bht_pkg::CMD_INSERT) begin
      row_mem[bkt_r][sidx_r] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == bht_pkg::BS_OVF && !o_end && o_match &&
        cmd_r == bht_pkg::CMD_INSERT) begin
      okey_r[oi_r] <= key_r;
    end
  end

  // per-transaction working registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      bht_pkg::BS_IDLE: begin
        cmd_r <= q_cmd;
        key_r <= q_key;
        bkt_r <= q_bucket;
        ok_r <= 1'b0;
        loc_r <= bht_pkg::LOC_NOWHERE;
      end
      bht_pkg::BS_READ: begin
        rv_r <= bvalid_r[bkt_r];
        oi_r <= '0;
        ocnt_r <= '0;
      end
      bht_pkg::BS_SLOTS: begin
        sidx_r <= fidx;
        if (fhit && cmd_r != bht_pkg::CMD_NONE) begin
          ok_r <= 1'b1;
          loc_r <= bht_pkg::LOC_BUCKET;
        end
      end
      bht_pkg::BS_OVF: begin
        if (!o_end && o_match) begin
          ok_r <= 1'b1;
          loc_r <= bht_pkg::LOC_OVERFLOW;
        end
        oi_r <= oi_r + OW'(1);
        ocnt_r <= ocnt_r + OCW'(1);
      end
      bht_pkg::BS_WRITE: begin
        rv_r <= rv_upd;
      end
      default: begin
      end
    endcase
  end

  assign out_valid = (state_r == bht_pkg::BS_OUT);
  assign out_success = ok_r;
  assign out_location = loc_r;
  assign out_bucket_index = bht_pkg::BI_W'(bkt_r);
  assign out_fill_count = bht_pkg::FC_W'(fill);
endmodule

[design/bucketed_hash_table_with_overflow.sv]
// Top level: bucketed hash table with a shared overflow area.
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_cmd, in_key
//  out     | output    | out_valid/out_stall| out_success, out_location,
//          |           |                    | out_bucket_index, out_fill_count
//  cfg     | input     | cfg_we             | cfg_index, cfg_data
// Each transaction passes the front divider (bit-serial remainder) and then
// the engine (row read, slot check, overflow scan one entry a cycle, write,
// result). Front and back overlap: the front end divides the next key while
// the engine works on the last. After reset the engine clears the bucket valid
// rows in a pass over all NUM_BUCKETS buckets before taking work. A stalled
// output holds the engine, and the front end waits once the queue is full.
module bucketed_hash_table_with_overflow #(
  parameter int NUM_BUCKETS = bht_pkg::NUM_BUCKETS_DEF,
  parameter int SLOTS_PER_BUCKET = bht_pkg::SLOTS_PER_BUCKET_DEF,
  parameter int OVERFLOW_DEPTH = bht_pkg::OVERFLOW_DEPTH_DEF,
  parameter int KEY_WIDTH = bht_pkg::KEY_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_cmd,
  input  logic [KEY_WIDTH-1:0]      in_key,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_success,
  output logic [1:0]                out_location,
  output logic [bht_pkg::BI_W-1:0]  out_bucket_index,
  output logic [bht_pkg::FC_W-1:0]  out_fill_count,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [bht_pkg::CFG_W-1:0] cfg_data
);
  localparam int BW = $clog2(NUM_BUCKETS);
  localparam int QW = 2 + KEY_WIDTH + BW;

  logic [bht_pkg::TS_W-1:0] table_size_r;
  logic [bht_pkg::OS_W-1:0] overflow_slots_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= bht_pkg::TS_RESET;
      overflow_slots_r <= bht_pkg::OS_RESET;
    end else if (cfg_we) begin
      unique case (bht_pkg::reg_idx_t'(cfg_index))
        bht_pkg::REG_TABLE_SIZE: table_size_r <= cfg_data;
        bht_pkg::REG_OVERFLOW_SLOTS: overflow_slots_r <= cfg_data[bht_pkg::OS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  logic q_push, q_full, q_pop, q_empty;
  logic [1:0] f_cmd;
  logic [KEY_WIDTH-1:0] f_key;
  logic [BW-1:0] f_bkt;
  logic [QW-1:0] q_dout;

  bht_front #(.KEY_WIDTH(KEY_WIDTH), .NUM_BUCKETS(NUM_BUCKETS), .BW(BW)) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_cmd, .in_key,
    .table_size(table_size_r), .q_push, .q_full,
    .q_cmd(f_cmd), .q_key(f_key), .q_bucket(f_bkt)
  );

  bht_queue #(.W(QW), .DEPTH(2)) u_queue (
    .clk, .rst_n, .push(q_push), .din({f_cmd, f_key, f_bkt}), .full(q_full),
    .pop(q_pop), .empty(q_empty), .dout(q_dout)
  );

  bht_engine #(
    .KEY_WIDTH(KEY_WIDTH), .NUM_BUCKETS(NUM_BUCKETS),
    .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET), .OVERFLOW_DEPTH(OVERFLOW_DEPTH), .BW(BW)
  ) u_engine (
    .clk, .rst_n, .q_empty, .q_pop,
    .q_cmd(q_dout[QW-1 -: 2]), .q_key(q_dout[BW +: KEY_WIDTH]), .q_bucket(q_dout[BW-1:0]),
    .overflow_slots(overflow_slots_r),
    .out_valid, .out_stall, .out_success, .out_location, .out_bucket_index, .out_fill_count
  );
endmodule

[design/bht_checker.sv]
// Port-level checker for the hash table, bound to the top level.
module bht_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_stall,
  input logic       out_success,
  input logic [1:0] out_location,
  input logic [2:0] out_fill_count
);
  // a failed transaction reports nowhere
  a_fail_loc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_success |-> out_location == bht_pkg::LOC_NOWHERE)
    else $error("failure not reported as nowhere");
  // a success is in the bucket or the overflow area
  a_ok_loc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_success |-> out_location != bht_pkg::LOC_NOWHERE)
    else $error("success reported as nowhere");
  // fill count never exceeds the bucket size
  a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_fill_count <= 3'd5)
    else $error("fill count out of range");
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_location))
    else $error("stalled result changed");
endmodule

bind bucketed_hash_table_with_overflow bht_checker u_chk (
  .clk, .rst_n, .out_valid, .out_stall, .out_success, .out_location, .out_fill_count
);
